// ===== rtl/dml_pkg.sv =====
// Shared types, codes and format decode functions for the DDS mip chain layout block.
`timescale 1ns / 1ps

package dml_pkg;

  typedef logic [3:0] fmt_t;
  typedef logic [1:0] status_t;

  localparam fmt_t FMT_UNKNOWN = 4'd0;
  localparam fmt_t FMT_RGBA8   = 4'd1;
  localparam fmt_t FMT_BC1     = 4'd2;
  localparam fmt_t FMT_BC2     = 4'd3;
  localparam fmt_t FMT_BC3     = 4'd4;
  localparam fmt_t FMT_BC4U    = 4'd5;
  localparam fmt_t FMT_BC4S    = 4'd6;
  localparam fmt_t FMT_BC5U    = 4'd7;
  localparam fmt_t FMT_BC5S    = 4'd8;
  localparam fmt_t FMT_BC7     = 4'd9;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_SHORT   = 2'd1;
  localparam status_t ST_NO_SIZE = 2'd2;

  localparam int unsigned MAX_MIPS = 15;
  localparam int unsigned MAX_DIM  = 16384;
  localparam int unsigned DIM_W    = 15;
  localparam int unsigned PROD_W   = 2 * DIM_W;
  localparam int unsigned SIZE_W   = PROD_W + 4;

  localparam logic [31:0] HDR_BYTES    = 32'd128;
  localparam logic [31:0] DX10_HDR_END = 32'd148;

  // Pixel-format flag masks
  localparam int unsigned FLAG_FOURCC_BIT = 2;
  localparam logic [31:0] FLAG_RGBA       = 32'h0000_0041;

  // FourCC codes, first character in the low byte
  localparam logic [31:0] FCC_DX10 = 32'h3031_5844;
  localparam logic [31:0] FCC_DXT1 = 32'h3154_5844;
  localparam logic [31:0] FCC_DXT2 = 32'h3254_5844;
  localparam logic [31:0] FCC_DXT3 = 32'h3354_5844;
  localparam logic [31:0] FCC_DXT4 = 32'h3454_5844;
  localparam logic [31:0] FCC_DXT5 = 32'h3554_5844;
  localparam logic [31:0] FCC_ATI1 = 32'h3149_5441;
  localparam logic [31:0] FCC_ATI2 = 32'h3249_5441;
  localparam logic [31:0] FCC_BC4U = 32'h5534_4342;
  localparam logic [31:0] FCC_BC4S = 32'h5334_4342;
  localparam logic [31:0] FCC_BC5U = 32'h5535_4342;
  localparam logic [31:0] FCC_BC5S = 32'h5335_4342;

  // DXGI format numbers
  localparam logic [7:0] DXGI_RGBA8 = 8'd28;
  localparam logic [7:0] DXGI_BC1   = 8'd71;
  localparam logic [7:0] DXGI_BC2   = 8'd74;
  localparam logic [7:0] DXGI_BC3   = 8'd77;
  localparam logic [7:0] DXGI_BC4U  = 8'd80;
  localparam logic [7:0] DXGI_BC4S  = 8'd81;
  localparam logic [7:0] DXGI_BC5U  = 8'd83;
  localparam logic [7:0] DXGI_BC5S  = 8'd84;
  localparam logic [7:0] DXGI_BC7   = 8'd98;

  function automatic fmt_t from_dxgi(input logic [7:0] d);
    fmt_t f;
    unique case (d)
      DXGI_RGBA8: f = FMT_RGBA8;
      DXGI_BC1:   f = FMT_BC1;
      DXGI_BC2:   f = FMT_BC2;
      DXGI_BC3:   f = FMT_BC3;
      DXGI_BC4U:  f = FMT_BC4U;
      DXGI_BC4S:  f = FMT_BC4S;
      DXGI_BC5U:  f = FMT_BC5U;
      DXGI_BC5S:  f = FMT_BC5S;
      DXGI_BC7:   f = FMT_BC7;
      default:    f = FMT_UNKNOWN;
    endcase
    return f;
  endfunction

  function automatic fmt_t from_fourcc(input logic [31:0] c);
    fmt_t f;
    unique case (c)
      FCC_DXT1:           f = FMT_BC1;
      FCC_DXT2, FCC_DXT3: f = FMT_BC2;
      FCC_DXT4, FCC_DXT5: f = FMT_BC3;
      FCC_ATI1, FCC_BC4U: f = FMT_BC4U;
      FCC_BC4S:           f = FMT_BC4S;
      FCC_ATI2, FCC_BC5U: f = FMT_BC5U;
      FCC_BC5S:           f = FMT_BC5S;
      default:            f = FMT_UNKNOWN;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/dds_mip_chain_layout.sv =====
// Top level: DDS header decode and per-level mip offset and size sequencer.
`timescale 1ns / 1ps

// Takes one parsed DDS header per transfer and returns one result per mip
// level (offset, clamped size, format, status, last). After the header
// transfer each level passes through a multiply state on the shared 15x15
// multiplier (width times height, or block columns times block rows), a
// state that scales and clamps the size against the remaining file bytes,
// and a wait state in which the result sits in the output register until
// its transfer. in_stall stays high from the header transfer until the last
// result has been transferred. A DX10 header on a file shorter than 148
// bytes gives a single error result straight away.
module dds_mip_chain_layout (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_pixel_flags,
  input  logic [31:0]        in_four_cc,
  input  logic [7:0]         in_dxgi_format,
  input  logic [14:0]        in_image_width,
  input  logic [14:0]        in_image_height,
  input  logic [3:0]         in_mip_levels,
  input  logic [31:0]        in_file_bytes,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_level_index,
  output logic [31:0]        out_level_offset,
  output logic [31:0]        out_level_bytes,
  output dml_pkg::fmt_t      out_format_code,
  output dml_pkg::status_t   out_status,
  output logic               out_last
);
  import dml_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_SIZE = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  fmt_t              fmt_r;
  status_t           status_r;
  logic [DIM_W-1:0]  w_r, h_r;
  logic [3:0]        mips_r, idx_r;
  logic [31:0]       off_r, fbytes_r, rem_r;
  logic [PROD_W-1:0] prod_r;
  logic              out_valid_r;
  logic [3:0]        out_idx_r;
  logic [31:0]       out_off_r, out_bytes_r;
  fmt_t              out_fmt_r;
  status_t           out_status_r;
  logic              out_last_r;

  logic              in_xfer, out_xfer;
  logic              has_fourcc, is_dx10, too_short;
  fmt_t              fmt_dec;
  logic [DIM_W-1:0]  w_sat, h_sat;
  logic [3:0]        mips_dec;
  logic [DIM_W-1:0]  op_a, op_b;
  logic [DIM_W-1:0]  bw, bh;
  logic [DIM_W-1:0]  w_half, h_half;
  logic [SIZE_W-1:0] size_full, size_clamp;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // Header decode
  assign has_fourcc = in_pixel_flags[FLAG_FOURCC_BIT];
  assign is_dx10    = has_fourcc && (in_four_cc == FCC_DX10);
  assign too_short  = is_dx10 && (in_file_bytes < DX10_HDR_END);

  always_comb begin
    if (has_fourcc) begin
      fmt_dec = is_dx10 ? from_dxgi(in_dxgi_format) : from_fourcc(in_four_cc);
    end else if ((in_pixel_flags & FLAG_RGBA) == FLAG_RGBA) begin
      fmt_dec = FMT_RGBA8;
    end else begin
      fmt_dec = FMT_UNKNOWN;
    end
  end

  // Saturate dimensions and clamp mip count
  assign w_sat = (32'(in_image_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : in_image_width;
  assign h_sat = (32'(in_image_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : in_image_height;

  always_comb begin
    if (in_mip_levels == 4'd0) begin
      mips_dec = 4'd1;
    end else if (32'(in_mip_levels) > MAX_MIPS) begin
      mips_dec = 4'(MAX_MIPS);
    end else begin
      mips_dec = in_mip_levels;
    end
  end

  // Shared multiplier operands: pixels for RGBA8, 4x4 blocks otherwise (at least one)
  assign bw   = ((w_r + DIM_W'(3)) >> 2 == '0) ? DIM_W'(1) : (w_r + DIM_W'(3)) >> 2;
  assign bh   = ((h_r + DIM_W'(3)) >> 2 == '0) ? DIM_W'(1) : (h_r + DIM_W'(3)) >> 2;
  assign op_a = (fmt_r == FMT_RGBA8) ? w_r : bw;
  assign op_b = (fmt_r == FMT_RGBA8) ? h_r : bh;

  // Scale the product by bytes per pixel or per block
  always_comb begin
    case (fmt_r)
      FMT_RGBA8:                    size_full = SIZE_W'(prod_r) << 2;
      FMT_BC1, FMT_BC4U, FMT_BC4S:  size_full = SIZE_W'(prod_r) << 3;
      FMT_BC2, FMT_BC3, FMT_BC5U, FMT_BC5S, FMT_BC7:
                                    size_full = SIZE_W'(prod_r) << 4;
      default:                      size_full = '0;
    endcase
  end

  assign size_clamp = (size_full > SIZE_W'(rem_r)) ? SIZE_W'(rem_r) : size_full;

  assign w_half = ((w_r >> 1) == '0) ? DIM_W'(1) : (w_r >> 1);
  assign h_half = ((h_r >> 1) == '0) ? DIM_W'(1) : (h_r >> 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = too_short ? S_WAIT : S_MUL;
      end
      S_MUL:  state_nxt = S_SIZE;
      S_SIZE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (out_xfer) state_nxt = out_last_r ? S_IDLE : S_MUL;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            // Latch the decoded header; short DX10 files answer at once
            fmt_r    <= fmt_dec;
            status_r <= (fmt_dec == FMT_UNKNOWN) ? ST_NO_SIZE : ST_OK;
            w_r      <= w_sat;
            h_r      <= h_sat;
            mips_r   <= mips_dec;
            idx_r    <= 4'd0;
            off_r    <= is_dx10 ? DX10_HDR_END : HDR_BYTES;
            fbytes_r <= in_file_bytes;
            if (too_short) begin
              out_valid_r  <= 1'b1;
              out_idx_r    <= 4'd0;
              out_off_r    <= '0;
              out_bytes_r  <= '0;
              out_fmt_r    <= FMT_UNKNOWN;
              out_status_r <= ST_SHORT;
              out_last_r   <= 1'b1;
            end
          end
        end
        S_MUL: begin
          prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
          rem_r  <= (fbytes_r > off_r) ? (fbytes_r - off_r) : '0;
        end
        S_SIZE: begin
          out_valid_r  <= 1'b1;
          out_idx_r    <= idx_r;
          out_off_r    <= off_r;
          out_bytes_r  <= size_clamp[31:0];
          out_fmt_r    <= fmt_r;
          out_status_r <= status_r;
          out_last_r   <= (idx_r == mips_r - 4'd1);
        end
        S_WAIT: begin
          if (out_xfer) begin
            // Advance to the next level: step offset, halve dimensions
            out_valid_r <= 1'b0;
            idx_r       <= idx_r + 4'd1;
            off_r       <= off_r + out_bytes_r;
            w_r         <= w_half;
            h_r         <= h_half;
          end
        end
        default: out_valid_r <= 1'b0;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_level_index  = out_idx_r;
  assign out_level_offset = out_off_r;
  assign out_level_bytes  = out_bytes_r;
  assign out_format_code  = out_fmt_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  // A result only waits while the header side is held off
  a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result pending while input open");

  // A short DX10 file gives exactly one result
  a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_SHORT) |-> out_last)
    else $error("short file result not marked last");

  // Formats without a size never report bytes
  a_nosize_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NO_SIZE) |-> (out_level_bytes == 32'd0))
    else $error("unsized format reported bytes");

  // After the last transfer the block returns to accepting headers
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> (!out_valid && !in_stall))
    else $error("block not released after last result");

  // Next level follows the previous one at offset plus size
  a_offset_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> (off_r == $past(out_level_offset)
      + $past(out_level_bytes)))
    else $error("level offset chain broken");

endmodule

// ===== verif/dds_mip_chain_layout_tb.sv =====
// Self-checking testbench for the DDS mip chain layout block.
`timescale 1ns / 1ps

typedef struct packed {
  logic [31:0] pixel_flags;
  logic [31:0] four_cc;
  logic [7:0]  dxgi_format;
  logic [14:0] image_width;
  logic [14:0] image_height;
  logic [3:0]  mip_levels;
  logic [31:0] file_bytes;
} mip_header_t;

typedef struct packed {
  logic [3:0]        level_index;
  logic [31:0]       level_offset;
  logic [31:0]       level_bytes;
  dml_pkg::fmt_t     format_code;
  dml_pkg::status_t  status;
  logic              last;
} mip_level_t;

class mip_layout_board;
  mip_level_t  levels_due[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  task report(string what);
    if (errors < 40) $display("MISMATCH %0t: %s", $realtime, what);
    errors++;
  endtask

  // Append one expected level at the tail of the queue.
  function void append_level(mip_level_t lv);
    levels_due = {levels_due, lv};
  endfunction

  function dml_pkg::fmt_t decode_format(mip_header_t hd);
    if (hd.pixel_flags[dml_pkg::FLAG_FOURCC_BIT]) begin
      if (hd.four_cc == dml_pkg::FCC_DX10) begin
        case (hd.dxgi_format)
          dml_pkg::DXGI_RGBA8: return dml_pkg::FMT_RGBA8;
          dml_pkg::DXGI_BC1:   return dml_pkg::FMT_BC1;
          dml_pkg::DXGI_BC2:   return dml_pkg::FMT_BC2;
          dml_pkg::DXGI_BC3:   return dml_pkg::FMT_BC3;
          dml_pkg::DXGI_BC4U:  return dml_pkg::FMT_BC4U;
          dml_pkg::DXGI_BC4S:  return dml_pkg::FMT_BC4S;
          dml_pkg::DXGI_BC5U:  return dml_pkg::FMT_BC5U;
          dml_pkg::DXGI_BC5S:  return dml_pkg::FMT_BC5S;
          dml_pkg::DXGI_BC7:   return dml_pkg::FMT_BC7;
          default:             return dml_pkg::FMT_UNKNOWN;
        endcase
      end
      case (hd.four_cc)
        dml_pkg::FCC_DXT1:                   return dml_pkg::FMT_BC1;
        dml_pkg::FCC_DXT2, dml_pkg::FCC_DXT3: return dml_pkg::FMT_BC2;
        dml_pkg::FCC_DXT4, dml_pkg::FCC_DXT5: return dml_pkg::FMT_BC3;
        dml_pkg::FCC_ATI1, dml_pkg::FCC_BC4U: return dml_pkg::FMT_BC4U;
        dml_pkg::FCC_BC4S:                   return dml_pkg::FMT_BC4S;
        dml_pkg::FCC_ATI2, dml_pkg::FCC_BC5U: return dml_pkg::FMT_BC5U;
        dml_pkg::FCC_BC5S:                   return dml_pkg::FMT_BC5S;
        default:                             return dml_pkg::FMT_UNKNOWN;
      endcase
    end
    if ((hd.pixel_flags & dml_pkg::FLAG_RGBA) == dml_pkg::FLAG_RGBA)
      return dml_pkg::FMT_RGBA8;
    return dml_pkg::FMT_UNKNOWN;
  endfunction

  // Work out every level of one header and queue them in order.
  function void note_header(mip_header_t hd);
    dml_pkg::fmt_t    fmt;
    dml_pkg::status_t st;
    logic [63:0]      off, w, h, sz, rem, bw, bh, blk;
    int unsigned      mips;
    mip_level_t       lv;
    if (hd.pixel_flags[dml_pkg::FLAG_FOURCC_BIT] && hd.four_cc == dml_pkg::FCC_DX10 &&
        hd.file_bytes < dml_pkg::DX10_HDR_END) begin
      lv = '0;
      lv.status = dml_pkg::ST_SHORT;
      lv.last = 1'b1;
      append_level(lv);
      return;
    end
    fmt = decode_format(hd);
    off = (hd.pixel_flags[dml_pkg::FLAG_FOURCC_BIT] && hd.four_cc == dml_pkg::FCC_DX10) ?
          64'(dml_pkg::DX10_HDR_END) : 64'(dml_pkg::HDR_BYTES);
    st = (fmt == dml_pkg::FMT_UNKNOWN) ? dml_pkg::ST_NO_SIZE : dml_pkg::ST_OK;
    mips = (hd.mip_levels == 0) ? 1 : hd.mip_levels;
    if (mips > dml_pkg::MAX_MIPS) mips = dml_pkg::MAX_MIPS;
    w = (hd.image_width > dml_pkg::MAX_DIM) ? 64'(dml_pkg::MAX_DIM) : 64'(hd.image_width);
    h = (hd.image_height > dml_pkg::MAX_DIM) ? 64'(dml_pkg::MAX_DIM) : 64'(hd.image_height);
    case (fmt)
      dml_pkg::FMT_BC1, dml_pkg::FMT_BC4U, dml_pkg::FMT_BC4S: blk = 8;
      dml_pkg::FMT_BC2, dml_pkg::FMT_BC3, dml_pkg::FMT_BC5U,
      dml_pkg::FMT_BC5S, dml_pkg::FMT_BC7:                    blk = 16;
      default:                                               blk = 0;
    endcase
    for (int unsigned i = 0; i < mips; i++) begin
      if (fmt == dml_pkg::FMT_RGBA8) begin
        sz = w * 4 * h;
      end else begin
        bw = (w + 3) / 4;
        bh = (h + 3) / 4;
        if (bw == 0) bw = 1;
        if (bh == 0) bh = 1;
        sz = bw * bh * blk;
      end
      rem = (64'(hd.file_bytes) > off) ? 64'(hd.file_bytes) - off : 64'd0;
      if (sz > rem) sz = rem;
      lv.level_index  = 4'(i);
      lv.level_offset = off[31:0];
      lv.level_bytes  = sz[31:0];
      lv.format_code  = fmt;
      lv.status       = st;
      lv.last         = (i + 1 == mips);
      append_level(lv);
      off = off + sz;
      w = (w / 2 == 0) ? 64'd1 : w / 2;
      h = (h / 2 == 0) ? 64'd1 : h / 2;
    end
  endfunction

  task check_level(mip_level_t got);
    mip_level_t want;
    if (levels_due.size() == 0) begin
      report($sformatf("unexpected level %0d offset %0d bytes %0d",
                       got.level_index, got.level_offset, got.level_bytes));
      return;
    end
    want = levels_due.pop_front();
    if (got !== want)
      report($sformatf({"level got idx %0d off %0d bytes %0d fmt %0d st %0d last %0d, ",
                        "want idx %0d off %0d bytes %0d fmt %0d st %0d last %0d"},
                       got.level_index, got.level_offset, got.level_bytes,
                       got.format_code, got.status, got.last,
                       want.level_index, want.level_offset, want.level_bytes,
                       want.format_code, want.status, want.last));
  endtask

  function int unsigned pending();
    return levels_due.size();
  endfunction
endclass

module dds_mip_chain_layout_tb;
  import dml_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned RANDOM_PER_PHASE = 18;

  // FourCC codes in a table; the last entry selects the DX10 extension.
  localparam logic [31:0] FCC_CODES [12] = '{
    FCC_DXT1, FCC_DXT2, FCC_DXT3, FCC_DXT4, FCC_DXT5, FCC_ATI1,
    FCC_ATI2, FCC_BC4U, FCC_BC4S, FCC_BC5U, FCC_BC5S, FCC_DX10
  };
  localparam logic [7:0] DXGI_CODES [9] = '{
    DXGI_RGBA8, DXGI_BC1, DXGI_BC2, DXGI_BC3, DXGI_BC4U,
    DXGI_BC4S, DXGI_BC5U, DXGI_BC5S, DXGI_BC7
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_pixel_flags = '0;
  logic [31:0] in_four_cc = '0;
  logic [7:0]  in_dxgi_format = '0;
  logic [14:0] in_image_width = '0;
  logic [14:0] in_image_height = '0;
  logic [3:0]  in_mip_levels = '0;
  logic [31:0] in_file_bytes = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_level_index;
  logic [31:0] out_level_offset;
  logic [31:0] out_level_bytes;
  fmt_t        out_format_code;
  status_t     out_status;
  logic        out_last;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  mip_layout_board board = new();

  dds_mip_chain_layout DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_flags   (in_pixel_flags),
    .in_four_cc       (in_four_cc),
    .in_dxgi_format   (in_dxgi_format),
    .in_image_width   (in_image_width),
    .in_image_height  (in_image_height),
    .in_mip_levels    (in_mip_levels),
    .in_file_bytes    (in_file_bytes),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_level_index  (out_level_index),
    .out_level_offset (out_level_offset),
    .out_level_bytes  (out_level_bytes),
    .out_format_code  (out_format_code),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: stall at random and check every level transfer.
  // out_stall read here is the value that held at this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        board.check_level({out_level_index, out_level_offset, out_level_bytes,
                           out_format_code, out_status, out_last});
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("dds_mip_chain_layout_tb: errors");
        $finish;
      end
    end
  end

  // Present one header, hold it until it transfers, then queue its levels.
  // Idle cycles, with valid low, are inserted before raising valid; with none, valid stays high.
  task automatic send_header(input mip_header_t hd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_pixel_flags  <= hd.pixel_flags;
    in_four_cc      <= hd.four_cc;
    in_dxgi_format  <= hd.dxgi_format;
    in_image_width  <= hd.image_width;
    in_image_height <= hd.image_height;
    in_mip_levels   <= hd.mip_levels;
    in_file_bytes   <= hd.file_bytes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_header(hd);
  endtask

  task automatic send_fields(input logic [31:0] flags, input logic [31:0] fcc,
                             input logic [7:0] dxgi, input logic [14:0] w,
                             input logic [14:0] h, input logic [3:0] mips,
                             input logic [31:0] fbytes);
    send_header('{flags, fcc, dxgi, w, h, mips, fbytes});
  endtask

  function automatic logic [31:0] pick_file_bytes();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(0, 4096);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  function automatic logic [14:0] pick_dim();
    if ($urandom_range(9) == 0) return 15'($urandom_range(0, 32767));
    return 15'($urandom_range(0, 600));
  endfunction

  // Mostly well-formed headers of a known format with random content,
  // the rest random noise.
  function automatic mip_header_t random_header();
    mip_header_t hd;
    int unsigned kind;
    hd.pixel_flags  = $urandom;
    hd.four_cc      = $urandom;
    hd.dxgi_format  = 8'($urandom);
    hd.image_width  = pick_dim();
    hd.image_height = pick_dim();
    hd.mip_levels   = 4'($urandom);
    hd.file_bytes   = pick_file_bytes();
    kind = $urandom_range(99);
    if (kind < 45) begin
      hd.pixel_flags[FLAG_FOURCC_BIT] = 1'b1;
      hd.four_cc = FCC_CODES[$urandom_range(0, 11)];
      if ($urandom_range(4) != 0) hd.dxgi_format = DXGI_CODES[$urandom_range(0, 8)];
    end else if (kind < 60) begin
      hd.pixel_flags[FLAG_FOURCC_BIT] = 1'b1;
      hd.four_cc = FCC_DX10;
      hd.dxgi_format = DXGI_CODES[$urandom_range(0, 8)];
    end else if (kind < 80) begin
      hd.pixel_flags[FLAG_FOURCC_BIT] = 1'b0;
      hd.pixel_flags = hd.pixel_flags | FLAG_RGBA;
    end
    return hd;
  endfunction

  initial begin
    int unsigned idle_pct [4] = '{0, 45, 0, 21};
    int unsigned stall_pct [4] = '{0, 0, 45, 21};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling.
    // RGBA8 at the largest size with the deepest chain.
    send_fields(FLAG_RGBA, 32'h0, 8'h0, 15'd16384, 15'd16384, 4'd15, 32'hFFFF_FFFF);
    // RGBA8 with zero dimensions: the first level has size zero, status ok.
    send_fields(32'hFFFF_FFFB, 32'hFFFF_FFFF, 8'hFF, 15'd0, 15'd0, 4'd3, 32'd100000);
    // Unknown format: no size, offsets stay put.
    send_fields(32'h0, FCC_DXT1, DXGI_BC1, 15'd64, 15'd64, 4'd4, 32'd5000);
    // Every FourCC but DX10; dimensions above the maximum saturate, a zero mip count means one.
    for (int i = 0; i < 11; i++)
      send_fields(32'h4, FCC_CODES[i], 8'h0, (i % 2) ? 15'h7FFF : 15'd37,
                  (i % 3) ? 15'd1 : 15'h7FFF, 4'(i), 32'd70000);
    // DX10 path with every DXGI format and one unknown number.
    for (int i = 0; i < 9; i++)
      send_fields(32'h4, FCC_DX10, DXGI_CODES[i], 15'd256, 15'd100, 4'd9, 32'd400000);
    send_fields(32'h4, FCC_DX10, 8'd0, 15'd8, 15'd8, 4'd2, 32'd148);
    // Short DX10 file gives the single error result.
    send_fields(32'h4, FCC_DX10, DXGI_BC7, 15'd16, 15'd16, 4'd5, 32'd147);
    send_fields(32'hFFFF_FFFF, FCC_DX10, DXGI_BC1, 15'd16, 15'd16, 4'd5, 32'd0);
    // File shorter than the data start: every size clamps to zero.
    send_fields(32'h4, FCC_DXT5, 8'h0, 15'd64, 15'd64, 4'd7, 32'd100);

    // Random part across the idling phases.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_header(random_header());
    end
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle.
    while (board.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (board.errors == 0) begin
      $display("dds_mip_chain_layout_tb: clean");
    end else begin
      $display("dds_mip_chain_layout_tb: errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/dml_pkg.sv
rtl/dds_mip_chain_layout.sv
verif/dds_mip_chain_layout_tb.sv
